@@ sv/lag1_pkg.sv @@
// types, constants and step table for the lag-1 autocorrelation block
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package lag1_pkg;

  localparam int SAMPLE_W    = 20;
  localparam int SERIES_MAX  = 256;
  localparam int CNT_W       = 9;
  localparam int SUM_W       = 28;
  localparam int SQ_W        = 48;
  localparam int MM_W        = 17;
  localparam int MS_W        = 37;
  localparam int SPAN_W      = 29;
  localparam int OPND_W      = 32;
  localparam int PROD_W      = 2 * OPND_W;
  localparam int ACC_W       = 68;
  localparam int DEN_W       = 64;
  localparam int NUM_STEPS   = 13;
  localparam int STEP_W      = 4;
  localparam int FRAC_BITS   = 30;
  localparam int DIV_STEPS   = FRAC_BITS + 1;
  localparam int DIV_CNT_W   = 5;
  localparam int AC_W        = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                sample_present;
    logic                last_in_series;
  } item_t;

  typedef struct packed {
    logic signed [AC_W-1:0] autocorrelation;
    logic                   result_valid;
  } result_t;

  // finished series handed from the front to the back
  typedef struct packed {
    logic [CNT_W-1:0]    count;
    logic [SUM_W-1:0]    sum;
    logic [SQ_W-1:0]     sum_sq;
    logic [SQ_W-1:0]     sum_lag;
    logic [SAMPLE_W-1:0] first;
    logic [SAMPLE_W-1:0] last;
  } snap_t;

  typedef enum logic [2:0] {
    OPA_M, OPA_M1, OPA_MM, OPA_MS_LO, OPA_MS_HI, OPA_M1S_LO, OPA_M1S_HI
  } opa_t;

  typedef enum logic [2:0] {
    OPB_M, OPB_S, OPB_P_LO, OPB_P_HI, OPB_Q_LO, OPB_Q_HI, OPB_SPAN
  } opb_t;

  typedef enum logic [2:0] {
    DST_MM, DST_MS, DST_M1S, DST_NUM_ADD, DST_NUM_SUB, DST_DEN_ADD, DST_DEN_SUB
  } dst_t;

  typedef struct packed {
    opa_t opa;
    opb_t opb;
    dst_t dst;
    logic hi;
  } step_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL, B_DRAIN, B_PREP, B_DIV, B_DONE
  } back_state_t;

  // num = mm*P + (m-1)S*S - mS*span,  den = mm*Q - mS*S
  function automatic step_t step_ctl(input logic [STEP_W-1:0] idx);
    step_t c;
    case (idx)
      4'd0:    c = '{OPA_M,      OPB_M,    DST_MM,      1'b0};
      4'd1:    c = '{OPA_M,      OPB_S,    DST_MS,      1'b0};
      4'd2:    c = '{OPA_M1,     OPB_S,    DST_M1S,     1'b0};
      4'd3:    c = '{OPA_MM,     OPB_P_LO, DST_NUM_ADD, 1'b0};
      4'd4:    c = '{OPA_MM,     OPB_P_HI, DST_NUM_ADD, 1'b1};
      4'd5:    c = '{OPA_MS_LO,  OPB_SPAN, DST_NUM_SUB, 1'b0};
      4'd6:    c = '{OPA_MS_HI,  OPB_SPAN, DST_NUM_SUB, 1'b1};
      4'd7:    c = '{OPA_MM,     OPB_Q_LO, DST_DEN_ADD, 1'b0};
      4'd8:    c = '{OPA_MM,     OPB_Q_HI, DST_DEN_ADD, 1'b1};
      4'd9:    c = '{OPA_MS_LO,  OPB_S,    DST_DEN_SUB, 1'b0};
      4'd10:   c = '{OPA_MS_HI,  OPB_S,    DST_DEN_SUB, 1'b1};
      4'd11:   c = '{OPA_M1S_LO, OPB_S,    DST_NUM_ADD, 1'b0};
      4'd12:   c = '{OPA_M1S_HI, OPB_S,    DST_NUM_ADD, 1'b1};
      default: c = '{OPA_M,      OPB_M,    DST_MM,      1'b0};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/lag1_front.sv @@
// front end: accumulates kept samples of the running series
// depends on lag1_pkg; hands a snapshot to the queue on the last item
`timescale 1ns / 1ps
`default_nettype none

module lag1_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire lag1_pkg::item_t item,
  input  wire logic            accept,
  output lag1_pkg::snap_t      snap,
  output logic                 snap_push
);
  import lag1_pkg::*;

  logic [CNT_W-1:0]    count, count_next;
  logic [SUM_W-1:0]    sum, sum_next;
  logic [SQ_W-1:0]     sum_sq, sum_sq_next;
  logic [SQ_W-1:0]     sum_lag, sum_lag_next;
  logic [SAMPLE_W-1:0] first, first_next;
  logic [SAMPLE_W-1:0] prev, prev_next;
  logic                take;
  logic [2*SAMPLE_W-1:0] sq_prod, lag_prod;

  assign take     = item.sample_present && (count < CNT_W'(SERIES_MAX));
  assign sq_prod  = item.sample * item.sample;
  assign lag_prod = prev * item.sample;

  always_comb begin
    count_next   = count;
    sum_next     = sum;
    sum_sq_next  = sum_sq;
    sum_lag_next = sum_lag;
    first_next   = first;
    prev_next    = prev;
    if (take) begin
      count_next  = count + CNT_W'(1);
      sum_next    = sum + SUM_W'(item.sample);
      sum_sq_next = sum_sq + SQ_W'(sq_prod);
      prev_next   = item.sample;
      if (count == '0) begin
        first_next = item.sample;
      end else begin
        sum_lag_next = sum_lag + SQ_W'(lag_prod);
      end
    end
  end

  assign snap      = '{count_next, sum_next, sum_sq_next, sum_lag_next, first_next, prev_next};
  assign snap_push = accept && item.last_in_series;

  always_ff @(posedge clk) begin
    if (rst || snap_push) begin
      count   <= '0;
      sum     <= '0;
      sum_sq  <= '0;
      sum_lag <= '0;
      first   <= '0;
      prev    <= '0;
    end else if (accept) begin
      count   <= count_next;
      sum     <= sum_next;
      sum_sq  <= sum_sq_next;
      sum_lag <= sum_lag_next;
      first   <= first_next;
      prev    <= prev_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/lag1_queue.sv @@
// short queue of finished series between the front and the back
// depends on lag1_pkg for the snapshot type and depth
`timescale 1ns / 1ps
`default_nettype none

module lag1_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire lag1_pkg::snap_t wdata,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output lag1_pkg::snap_t      rdata
);
  import lag1_pkg::*;

  snap_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wptr, rptr;
  logic [QPTR_W:0]    fill;
  logic               do_push, do_pop;

  assign full    = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + (QPTR_W+1)'(1);
        2'b01:   fill <= fill - (QPTR_W+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/lag1_back.sv @@
// back end: products on one shared 32x32 multiplier, restoring divide,
// and the result register; depends on lag1_pkg
`timescale 1ns / 1ps
`default_nettype none

module lag1_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lag1_pkg::snap_t     snap,
  input  wire logic                snap_empty,
  output logic                     snap_pop,
  output lag1_pkg::result_t        result,
  output logic                     empty,
  input  wire logic                pop
);
  import lag1_pkg::*;

  localparam logic [FRAC_BITS:0] Q_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  back_state_t state, state_next;

  // output controls
  logic issue, prep, div_step, load_res, res_free;

  snap_t                   work;
  logic [STEP_W-1:0]       step;
  step_t                   ctl, pctl;
  logic                    pv;
  logic [OPND_W-1:0]       opa, opb;
  logic [PROD_W-1:0]       prod;
  logic [MM_W-1:0]         mm;
  logic [MS_W-1:0]         ms, m1s;
  logic [SPAN_W-1:0]       span;
  logic [CNT_W-1:0]        m_less1;
  logic signed [ACC_W-1:0] num, den, addend;

  logic                    neg, ok;
  logic [DEN_W-1:0]        rem;
  logic [FRAC_BITS:0]      shin;
  logic [FRAC_BITS:0]      quo;
  logic [DIV_CNT_W-1:0]    div_cnt;
  logic [DEN_W:0]          rem_sh, diff;
  logic                    ge;
  logic [ACC_W-1:0]        mag;
  logic [FRAC_BITS:0]      qsat;
  logic                    res_full;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (!snap_empty) state_next = B_MUL;
      B_MUL:   if (step == STEP_W'(NUM_STEPS - 1)) state_next = B_DRAIN;
      B_DRAIN: state_next = B_PREP;
      B_PREP:  state_next = B_DIV;
      B_DIV:   if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) state_next = B_DONE;
      B_DONE:  if (res_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    snap_pop = 1'b0;
    issue    = 1'b0;
    prep     = 1'b0;
    div_step = 1'b0;
    load_res = 1'b0;
    case (state)
      B_IDLE:  snap_pop = !snap_empty;
      B_MUL:   issue    = 1'b1;
      B_PREP:  prep     = 1'b1;
      B_DIV:   div_step = 1'b1;
      B_DONE:  load_res = res_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // operand selection
  assign ctl     = step_ctl(step);
  assign m_less1 = work.count - CNT_W'(1);
  assign span    = {1'b0, work.sum} + {1'b0, work.sum} - SPAN_W'(work.first)
                   - SPAN_W'(work.last);

  always_comb begin
    case (ctl.opa)
      OPA_M:      opa = OPND_W'(work.count);
      OPA_M1:     opa = OPND_W'(m_less1);
      OPA_MM:     opa = OPND_W'(mm);
      OPA_MS_LO:  opa = ms[OPND_W-1:0];
      OPA_MS_HI:  opa = OPND_W'(ms[MS_W-1:OPND_W]);
      OPA_M1S_LO: opa = m1s[OPND_W-1:0];
      OPA_M1S_HI: opa = OPND_W'(m1s[MS_W-1:OPND_W]);
      default:    opa = '0;
    endcase
    case (ctl.opb)
      OPB_M:    opb = OPND_W'(work.count);
      OPB_S:    opb = OPND_W'(work.sum);
      OPB_P_LO: opb = work.sum_lag[OPND_W-1:0];
      OPB_P_HI: opb = OPND_W'(work.sum_lag[SQ_W-1:OPND_W]);
      OPB_Q_LO: opb = work.sum_sq[OPND_W-1:0];
      OPB_Q_HI: opb = OPND_W'(work.sum_sq[SQ_W-1:OPND_W]);
      OPB_SPAN: opb = OPND_W'(span);
      default:  opb = '0;
    endcase
  end

  // registered product, folded into its target in the next cycle
  assign addend = pctl.hi ? $signed(ACC_W'(prod) << OPND_W) : $signed(ACC_W'(prod));

  always_ff @(posedge clk) begin
    if (snap_pop) begin
      work <= snap;
      step <= '0;
      num  <= '0;
      den  <= '0;
    end else begin
      if (issue) begin
        step <= step + STEP_W'(1);
      end
      if (pv) begin
        case (pctl.dst)
          DST_MM:      mm  <= prod[MM_W-1:0];
          DST_MS:      ms  <= prod[MS_W-1:0];
          DST_M1S:     m1s <= prod[MS_W-1:0];
          DST_NUM_ADD: num <= num + addend;
          DST_NUM_SUB: num <= num - addend;
          DST_DEN_ADD: den <= den + addend;
          DST_DEN_SUB: den <= den - addend;
          default:     ;
        endcase
      end
    end
    prod <= opa * opb;
    pctl <= ctl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= issue;
    end
  end

  // restoring division of |num| << 30 by den, quotient known below 2^31
  assign mag    = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
  assign rem_sh = {rem, shin[FRAC_BITS]};
  assign ge     = rem_sh >= {1'b0, den[DEN_W-1:0]};
  assign diff   = rem_sh - {1'b0, den[DEN_W-1:0]};

  always_ff @(posedge clk) begin
    if (prep) begin
      neg     <= num[ACC_W-1];
      ok      <= (work.count >= CNT_W'(2)) && !den[ACC_W-1] && (den != '0);
      rem     <= mag[DEN_W:1];
      shin    <= {mag[0], FRAC_BITS'(0)};
      quo     <= '0;
      div_cnt <= '0;
    end else if (div_step) begin
      rem     <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      shin    <= {shin[FRAC_BITS-1:0], 1'b0};
      quo     <= {quo[FRAC_BITS-1:0], ge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // result register
  assign qsat     = (quo > Q_ONE) ? Q_ONE : quo;
  assign res_free = !res_full || pop;
  assign empty    = !res_full;

  always_ff @(posedge clk) begin
    if (load_res) begin
      result.result_valid    <= ok;
      result.autocorrelation <= !ok ? '0 :
                                neg ? -$signed(AC_W'(qsat)) : $signed(AC_W'(qsat));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (load_res) begin
      res_full <= 1'b1;
    end else if (pop) begin
      res_full <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ sv/lag_one_autocorrelation.sv @@
// result path: the last item's snapshot enters the queue, then the back end pops it and runs
//   its multiply, drain, prep and divide states before loading the result register
// throughput: one request per cycle into the accumulators while full is low; the back end
//   works on one series at a time (13 shared-multiplier steps, 31 divide steps, 4 of control)
// full rises only while two finished series wait for the back end
// reset: rst, synchronous, clears accumulators, empties queue and result register
`timescale 1ns / 1ps
`default_nettype none

module lag_one_autocorrelation (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire lag1_pkg::item_t   item,
  output logic                   empty,
  input  wire logic              pop,
  output lag1_pkg::result_t      result
);
  import lag1_pkg::*;

  // request handshake into the front end
  logic  accept;
  snap_t front_snap, back_snap;
  logic  snap_push, snap_pop, snap_empty;

  assign accept = push && !full;

  // front: count, sum, sum of squares, lag products, first and previous sample
  lag1_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .accept    (accept),
    .snap      (front_snap),
    .snap_push (snap_push)
  );

  // queue of finished series; its full flag is the block's full
  lag1_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (snap_push),
    .wdata (front_snap),
    .full  (full),
    .pop   (snap_pop),
    .empty (snap_empty),
    .rdata (back_snap)
  );

  // back: numerator and denominator products, divide, result register
  lag1_back u_back (
    .clk        (clk),
    .rst        (rst),
    .snap       (back_snap),
    .snap_empty (snap_empty),
    .snap_pop   (snap_pop),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

`default_nettype wire

@@ sv/lag1_checker.sv @@
// port-level checks for the lag-1 autocorrelation block
// depends on lag1_pkg; bound to lag_one_autocorrelation below
`timescale 1ns / 1ps
`default_nettype none

module lag1_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              push,
  input wire logic              full,
  input wire lag1_pkg::item_t   item,
  input wire logic              empty,
  input wire logic              pop,
  input wire lag1_pkg::result_t result
);
  import lag1_pkg::*;

  // nothing waits right after reset
  a_empty_after_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  a_not_full_after_rst: assert property (@(posedge clk) rst |=> !full)
    else $error("request side full after reset");

  // an invalid result carries zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.result_valid) |-> (result.autocorrelation == '0))
    else $error("invalid result with nonzero value");

  // magnitude never beyond one in Q1.30
  a_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((result.autocorrelation <= 32'sd1073741824) &&
                (result.autocorrelation >= -32'sd1073741824)))
    else $error("autocorrelation outside [-1, 1]");

  // a waiting result stays put until it is taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished before it was taken");

endmodule

bind lag_one_autocorrelation lag1_checker u_lag1_checker (.*);

`default_nettype wire

@@ tb/lag_one_autocorrelation_test.sv @@
// self-checking testbench for the lag-1 autocorrelation block: directed series, an
// over-long series, back-to-back series and random series against an exact predictor
// depends on lag1_pkg and lag_one_autocorrelation
`timescale 1ns / 1ps

module lag_one_autocorrelation_test;

  import lag1_pkg::*;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};
  localparam int ITEMS_TARGET = 700;
  localparam int STALL_LIMIT  = 4000;   // cycles with no request taken on either side
  localparam int TAIL_CYCLES  = 120;    // idle tail after the last result, to catch stray results
  localparam int REPORT_LIMIT = 200;

  // how the samples of one random series are drawn
  typedef enum int {PAT_FULL, PAT_NARROW, PAT_CONST, PAT_EXTREME} sample_pattern_t;
  // receiver behavior for one stretch of cycles
  typedef enum int {POP_ALWAYS, POP_COIN, POP_SLOW} pop_mode_t;

  logic    clk  = 1'b0;
  logic    rst  = 1'b1;
  logic    push = 1'b0;
  logic    pop  = 1'b0;
  item_t   item = '0;
  logic    full;
  logic    empty;
  result_t result;

  lag_one_autocorrelation dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always #10 clk = ~clk;

  // predictor state: one open series
  logic [CNT_W-1:0]    kept;
  logic [SUM_W-1:0]    total;
  logic [SQ_W-1:0]     squares;
  logic [SQ_W-1:0]     lag_products;
  logic [SAMPLE_W-1:0] first_sample;
  logic [SAMPLE_W-1:0] prev_sample;

  result_t expected_autocorr[$];
  result_t oldest;
  int      error_count = 0;
  int      items_taken = 0;
  int      burst_left  = 0;
  int      quiet_cycles = 0;
  int      mode_left   = 0;
  pop_mode_t pop_mode  = POP_ALWAYS;

  // exact lag-1 autocorrelation of the open series in signed Q1.30
  function automatic result_t series_result();
    logic [159:0] m, s, num_pos, num_neg, den_pos, den_neg, mag, quo;
    result_t r;
    r = '0;
    m = 160'(kept);
    s = 160'(total);
    if (kept >= 2) begin
      // numerator split into its positive and negative halves to stay unsigned
      num_pos = m * m * lag_products + (m - 1) * s * s;
      num_neg = m * s * (2 * s - first_sample - prev_sample);
      den_pos = m * m * squares;
      den_neg = m * s * s;
      // zero variance leaves the result invalid
      if (den_pos > den_neg) begin
        mag = (num_pos >= num_neg) ? num_pos - num_neg : num_neg - num_pos;
        quo = (mag << FRAC_BITS) / (den_pos - den_neg);
        if (quo > (160'd1 << FRAC_BITS)) begin
          quo = 160'd1 << FRAC_BITS;
        end
        r.autocorrelation = (num_pos >= num_neg) ? quo[AC_W-1:0] : -quo[AC_W-1:0];
        r.result_valid = 1'b1;
      end
    end
    return r;
  endfunction

  // fold one accepted request into the open series; a last mark closes it
  task automatic absorb_item(input item_t it);
    // samples beyond the series limit are dropped, the series still ends on its mark
    if (it.sample_present && kept < SERIES_MAX) begin
      if (kept == 0) begin
        first_sample = it.sample;
      end else begin
        lag_products += SQ_W'(prev_sample) * SQ_W'(it.sample);
      end
      total   += SUM_W'(it.sample);
      squares += SQ_W'(it.sample) * SQ_W'(it.sample);
      prev_sample = it.sample;
      kept++;
    end
    if (it.last_in_series) begin
      expected_autocorr.insert(expected_autocorr.size(), series_result());
      kept = '0;
      total = '0;
      squares = '0;
      lag_products = '0;
      first_sample = '0;
      prev_sample = '0;
    end
  endtask

  // present one request and hold it until the block takes it
  task automatic send_item(input item_t it);
    @(negedge clk);
    push <= 1'b1;
    item <= it;
    do begin
      @(posedge clk);
    end while (full);
    items_taken++;
    absorb_item(it);
  endtask

  // bursts of random length with random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(12, 1);
      repeat (gap) begin
        @(negedge clk);
        push <= 1'b0;
      end
      burst_left = $urandom_range(40, 1);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic present,
                             input logic last);
    item_t it;
    it.sample = s;
    it.sample_present = present;
    it.last_in_series = last;
    send_item(it);
    pace_sender();
  endtask

  // sender holds off until every expected result has come back
  task automatic wait_for_results();
    @(negedge clk);
    push <= 1'b0;
    while (expected_autocorr.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic send_series(input int len, input sample_pattern_t pat);
    logic [SAMPLE_W-1:0] base, s;
    base = SAMPLE_W'($urandom());
    for (int i = 0; i < len; i++) begin
      case (pat)
        PAT_FULL:    s = SAMPLE_W'($urandom());
        PAT_NARROW:  s = base + SAMPLE_W'($urandom_range(3, 0));
        PAT_CONST:   s = base;
        default:     s = $urandom_range(1, 0) ? SAMPLE_MAX : '0;
      endcase
      send_sample(s, $urandom_range(7, 0) != 0, i == len - 1);
    end
  endtask

  // corner series: too few samples, zero variance, missing samples, sign extremes
  task automatic test_directed_cases();
    // equal samples at full scale: zero variance
    send_sample(SAMPLE_MAX, 1'b1, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1, 1'b1);
    // one kept sample only
    send_sample(20'd5, 1'b1, 1'b1);
    // series with nothing kept
    send_sample(SAMPLE_MAX, 1'b0, 1'b1);
    // alternating extremes, strongly negative
    send_sample('0, 1'b1, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1, 1'b0);
    send_sample('0, 1'b1, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1, 1'b1);
    // ramp with a gap in the middle and a missing sample on the last item
    send_sample(20'd1, 1'b1, 1'b0);
    send_sample(20'd2, 1'b1, 1'b0);
    send_sample(20'd999, 1'b0, 1'b0);
    send_sample(20'd3, 1'b1, 1'b0);
    send_sample(20'd4, 1'b1, 1'b0);
    send_sample(20'd77, 1'b0, 1'b1);
    // two kept samples, first high and last low
    send_sample(SAMPLE_MAX, 1'b1, 1'b0);
    send_sample('0, 1'b1, 1'b1);
    // monotonic ramp up to full scale, last sample kept
    send_sample('0, 1'b1, 1'b0);
    send_sample(SAMPLE_MAX >> 1, 1'b1, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1, 1'b1);
  endtask

  // more items than the series can hold, mostly present, all near full scale
  task automatic test_series_overflow();
    wait_for_results();
    for (int i = 0; i < SERIES_MAX + 12; i++) begin
      send_sample(SAMPLE_W'($urandom_range(32'hFFFFF, 32'hF0000)),
                  $urandom_range(15, 0) != 0, i == SERIES_MAX + 11);
    end
  endtask

  // short series at full rate so finished series pile up in front of the back end
  task automatic test_back_to_back();
    item_t it;
    wait_for_results();
    for (int i = 0; i < 16; i++) begin
      it.sample = SAMPLE_W'($urandom());
      it.sample_present = 1'($urandom_range(1, 0));
      it.last_in_series = (i % 2 == 1) || (i > 10);
      send_item(it);
    end
    wait_for_results();
  endtask

  // random series, mostly short, with the odd pause until the queue runs dry
  task automatic test_random_series();
    int len, pick;
    sample_pattern_t pat;
    while (items_taken < ITEMS_TARGET) begin
      pick = $urandom_range(99, 0);
      if (pick < 80) begin
        len = $urandom_range(10, 1);
      end else if (pick < 95) begin
        len = $urandom_range(40, 11);
      end else begin
        len = 1;
      end
      pat = sample_pattern_t'($urandom_range(3, 0));
      send_series(len, pat);
      if ($urandom_range(9, 0) == 0) begin
        wait_for_results();
      end
    end
  endtask

  // receiver stalls on its own pattern, changing mode every stretch of cycles
  always @(negedge clk) begin
    if (mode_left == 0) begin
      pop_mode  <= pop_mode_t'($urandom_range(2, 0));
      mode_left <= $urandom_range(200, 20);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (pop_mode)
      POP_ALWAYS: pop <= 1'b1;
      POP_COIN:   pop <= 1'($urandom_range(1, 0));
      default:    pop <= ($urandom_range(7, 0) == 0);
    endcase
  end

  // compare each returned result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_autocorr.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("%0t: unexpected result: expected none actual %0d valid %0b", $time,
                   result.autocorrelation, result.result_valid);
        end
      end else begin
        oldest = expected_autocorr.pop_front();
        if (result.autocorrelation !== oldest.autocorrelation) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("%0t: autocorrelation mismatch: expected %0d actual %0d", $time,
                     oldest.autocorrelation, result.autocorrelation);
          end
        end
        if (result.result_valid !== oldest.result_valid) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("%0t: result_valid mismatch: expected %0b actual %0b", $time,
                     oldest.result_valid, result.result_valid);
          end
        end
      end
    end
  end

  // watchdog: too long with no request taken on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    kept = '0;
    total = '0;
    squares = '0;
    lag_products = '0;
    first_sample = '0;
    prev_sample = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_series_overflow();
    test_back_to_back();
    test_random_series();

    // let the last results drain, then watch for strays
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
